// ===== rtl/core/rcr_pkg.sv =====
// Shared types and constants for the RC-discharge reflectance array reader.
// No dependencies; imported by rcr_step and rc_reflectance_array_reader.
package rcr_pkg;

    localparam int SENSOR_COUNT_DEF = 5;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int CHARGE_W  = 8;
    localparam int THRESH_W  = 16;
    localparam int INDEX_W   = 3;
    localparam int LINE_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CHARGE_W-1:0] CHARGE_RESET = 8'd2;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARGE_TICKS    = 2'd0,
        REG_BLACK_THRESHOLD = 2'd1
    } rcr_reg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] sensor_index;
        logic               drive_high;
        logic [LINE_W-1:0]  line_bits;
        logic               reading_taken;
        logic               round_done;
    } rcr_result_t;

endpackage

// ===== rtl/core/rc_reflectance_array_reader.sv =====
// Top level of the RC-discharge reflectance array reader: configuration
// registers, per-tick state (rcr_step) and the result register. Uses rcr_pkg.
//
//   channel   signals                                          direction
//   in        in_valid, in_stall, pin_level                    tick samples in
//   out       out_valid, out_stall, sensor_index, drive_high,  one result per tick
//             line_bits, reading_taken, round_done
//   cfg       cfg_write, cfg_index, cfg_data                   register writes
//
// One tick is taken per cycle; its result appears in the result register on
// the next cycle. The result register alone sets the rate: a tick is taken
// whenever that register is empty or being emptied in the same cycle.
// Reset clears the counter, selection, stored readings and round flag and
// restores charge_ticks to 2 and black_threshold to 15.
module rc_reflectance_array_reader #(
    parameter int SENSOR_COUNT = rcr_pkg::SENSOR_COUNT_DEF,
    parameter int COUNT_WIDTH  = rcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           pin_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rcr_pkg::INDEX_W-1:0]    sensor_index,
    output logic                           drive_high,
    output logic [rcr_pkg::LINE_W-1:0]     line_bits,
    output logic                           reading_taken,
    output logic                           round_done,
    input  logic                           cfg_write,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcr_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import rcr_pkg::*;

    logic [CHARGE_W-1:0] charge_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic                out_valid_reg;
    rcr_result_t         result;
    rcr_result_t         result_reg;
    logic                in_fire;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_reg <= CHARGE_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHARGE_TICKS:    charge_reg <= cfg_data[CHARGE_W-1:0];
                REG_BLACK_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                default:             ;
            endcase
        end
    end

    rcr_step #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_fire       (in_fire),
        .pin_level       (pin_level),
        .charge_ticks    (charge_reg),
        .black_threshold (thresh_reg),
        .result          (result)
    );

    // hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sensor_index  = result_reg.sensor_index;
    assign drive_high    = result_reg.drive_high;
    assign line_bits     = result_reg.line_bits;
    assign reading_taken = result_reg.reading_taken;
    assign round_done    = result_reg.round_done;

endmodule

// ===== rtl/core/rcr_step.sv =====
// Per-tick state of the reader: tick counter, charge phase, sensor selection,
// stored readings and round flag. Uses rcr_pkg; result goes to the top level.
module rcr_step #(
    parameter int SENSOR_COUNT = rcr_pkg::SENSOR_COUNT_DEF,
    parameter int COUNT_WIDTH  = rcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_fire,
    input  logic                          pin_level,
    input  logic [rcr_pkg::CHARGE_W-1:0]  charge_ticks,
    input  logic [rcr_pkg::THRESH_W-1:0]  black_threshold,
    output rcr_pkg::rcr_result_t          result
);
    import rcr_pkg::*;

    localparam int SEL_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CMP_W  = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SEL_W-1:0]       SEL_LAST  = SEL_W'(SENSOR_COUNT - 1);

    logic [COUNT_WIDTH-1:0] tick_reg, tick_next, tick_inc;
    logic                   charging_reg, charging_next, charging_mid;
    logic [SEL_W-1:0]       sel_reg, sel_next;
    logic [LINE_W-1:0]      bits_reg, bits_next;
    logic                   done_reg, done_next;
    logic                   take, black;
    logic [CMP_W-1:0]       tick_ext, inc_ext, charge_ext, thresh_ext;
    logic [LINE_W:0]        sel_ext;

    always_comb
    begin
        tick_ext   = CMP_W'(tick_reg);
        charge_ext = CMP_W'(charge_ticks);
        thresh_ext = CMP_W'(black_threshold);

        // release to input when the count meets the charge time exactly
        charging_mid = (tick_ext == charge_ext) ? 1'b0 : charging_reg;
        tick_inc     = (tick_reg == COUNT_MAX) ? tick_reg : tick_reg + 1'b1;
        inc_ext      = CMP_W'(tick_inc);

        take  = (inc_ext > charge_ext) && !charging_mid && !pin_level;
        black = inc_ext > thresh_ext;

        sel_ext       = (LINE_W + 1)'(sel_reg);
        tick_next     = tick_inc;
        charging_next = charging_mid;
        sel_next      = sel_reg;
        bits_next     = bits_reg;
        done_next     = done_reg;

        if (take)
        begin
            for (int i = 0; i < LINE_W; i++)
            begin
                if (sel_ext == (LINE_W + 1)'(i))
                begin
                    bits_next[i] = black;
                end
            end
            if (sel_reg == SEL_LAST)
            begin
                sel_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                sel_next = sel_reg + 1'b1;
            end
            // recharge the next sensor
            tick_next     = '0;
            charging_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            charging_reg <= 1'b1;
            sel_reg      <= '0;
            bits_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else if (tick_fire)
        begin
            tick_reg     <= tick_next;
            charging_reg <= charging_next;
            sel_reg      <= sel_next;
            bits_reg     <= bits_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        result.sensor_index  = INDEX_W'(sel_next);
        result.drive_high    = charging_next;
        result.line_bits     = bits_next;
        result.reading_taken = take;
        result.round_done    = done_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for rc_reflectance_array_reader: tick transfers in,
// per-tick results checked against a predictor of the sensor sequencing.
// Depends on rcr_pkg and the RTL top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PRINT_CAP      = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 pin_level = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [INDEX_W-1:0]   sensor_index;
    logic                 drive_high;
    logic [LINE_W-1:0]    line_bits;
    logic                 reading_taken;
    logic                 round_done;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CHARGE_TICKS;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    logic [CHARGE_W-1:0]        charge_setting;
    logic [THRESH_W-1:0]        black_level;
    logic [COUNT_WIDTH_DEF-1:0] ticks;
    logic                       charging;
    logic [INDEX_W-1:0]         current_sensor;
    logic [LINE_W-1:0]          stored_line;
    logic                       round_flag;

    bit          pin_samples[$];
    rcr_result_t results_due[$];
    int          samples_queued = 0;
    int          samples_taken = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          holdoff_reqs = 0;
    int          holdoff_served = 0;
    int          holdoff_left = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    rc_reflectance_array_reader u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pin_level     (pin_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sensor_index  (sensor_index),
        .drive_high    (drive_high),
        .line_bits     (line_bits),
        .reading_taken (reading_taken),
        .round_done    (round_done),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic rcr_result_t advance_tick(logic pin);
        rcr_result_t r;
        r.reading_taken = 1'b0;
        if (ticks == COUNT_WIDTH_DEF'(charge_setting))
            charging = 1'b0;
        if (ticks != COUNT_TOP)
            ticks = ticks + 1'b1;
        if (ticks > COUNT_WIDTH_DEF'(charge_setting) && !charging && !pin)
        begin
            stored_line[current_sensor] = (ticks > black_level);
            r.reading_taken = 1'b1;
            if (current_sensor == INDEX_W'(SENSOR_COUNT_DEF - 1))
            begin
                current_sensor = '0;
                round_flag = 1'b1;
            end
            else
            begin
                current_sensor = current_sensor + 1'b1;
            end
            ticks = '0;
            charging = 1'b1;
        end
        r.sensor_index = current_sensor;
        r.drive_high   = charging;
        r.line_bits    = stored_line;
        r.round_done   = round_flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // tick driver: hold a stalled transfer, otherwise offer the next sample or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(advance_tick(pin_level));
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pin_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    pin_level <= pin_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin : result_check
        rcr_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, 1);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (sensor_index !== want.sensor_index)
                        report_mismatch("sensor_index", want.sensor_index, sensor_index);
                    if (drive_high !== want.drive_high)
                        report_mismatch("drive_high", want.drive_high, drive_high);
                    if (line_bits !== want.line_bits)
                        report_mismatch("line_bits", want.line_bits, line_bits);
                    if (reading_taken !== want.reading_taken)
                        report_mismatch("reading_taken", want.reading_taken, reading_taken);
                    if (round_done !== want.round_done)
                        report_mismatch("round_done", want.round_done, round_done);
                end
            end
            if (holdoff_served != holdoff_reqs)
            begin
                holdoff_served = holdoff_reqs;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                out_stall <= 1'b1;
                holdoff_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_pin(bit level);
        pin_samples.push_back(level);
        samples_queued++;
    endtask

    // a well-formed reading: pin held high, then low once
    task automatic queue_reading(int high_len);
        repeat (high_len) queue_pin(1'b1);
        queue_pin(1'b0);
    endtask

    task automatic drain();
        while (samples_taken != samples_queued || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_CHARGE_TICKS:    charge_setting = value[CHARGE_W-1:0];
            REG_BLACK_THRESHOLD: black_level = value;
            default: ;
        endcase
    endtask

    // while charging, never drop below the count already reached: that would
    // leave the pin driven for good
    task automatic write_charge(logic [CHARGE_W-1:0] value);
        if (charging && ticks > COUNT_WIDTH_DEF'(value))
            value = ticks[CHARGE_W-1:0];
        write_reg(REG_CHARGE_TICKS, {8'($urandom), value});
    endtask

    task automatic random_phase(int budget, bit pressure);
        int queued;
        int len;
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            write_charge(8'd0);
        else if (pick < 3)
            write_charge(8'hFF);
        else if (pick < 5)
            write_charge(8'($urandom_range(255)));
        else
            write_charge(8'($urandom_range(1, 12)));
        case ($urandom_range(3))
            0:       write_reg(REG_BLACK_THRESHOLD, '0);
            1:       write_reg(REG_BLACK_THRESHOLD, '1);
            2:       write_reg(REG_BLACK_THRESHOLD,
                               16'(charge_setting) + 16'($urandom_range(24)));
            default: write_reg(REG_BLACK_THRESHOLD, 16'($urandom));
        endcase
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
        if (pressure)
            holdoff_reqs++;
        queued = 0;
        while (queued < budget)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(int'(charge_setting) + 24);
                queue_reading(len);
                queued += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) queue_pin(1'($urandom_range(1)));
                queued += len;
            end
        end
        drain();
    endtask

    initial
    begin : stimulus
        charge_setting = CHARGE_RESET;
        black_level    = THRESH_RESET;
        ticks          = '0;
        charging       = 1'b1;
        current_sensor = '0;
        stored_line    = '0;
        round_flag     = 1'b0;
        send_idle_pct  = 32;
        recv_idle_pct  = 59;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: low on the release tick, then a long discharge
        queue_reading(2);
        queue_reading(20);
        drain();

        // zero charge and threshold: every low tick reads black, round wraps
        write_charge(8'd0);
        write_reg(REG_BLACK_THRESHOLD, '0);
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        repeat (6) queue_pin(1'b0);
        drain();

        // raise the charge count mid-discharge: no reading until above it
        write_charge(8'd2);
        write_reg(REG_BLACK_THRESHOLD, 16'd100);
        repeat (4) queue_pin(1'b1);
        drain();
        write_charge(8'd200);
        repeat (200) queue_pin(1'b0);
        drain();

        repeat (4) random_phase(80, 1'b0);
        random_phase(80, 1'b1);

        send_idle_pct = 59;
        recv_idle_pct = 32;
        random_phase(80, 1'b1);
        repeat (3) random_phase(80, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) random_phase(80, 1'b0);

        // drop the charge count below a count already passed: pin stays driven
        write_charge(8'd10);
        repeat (3) queue_pin(1'b1);
        drain();
        write_reg(REG_CHARGE_TICKS, 16'd1);
        repeat (40) queue_pin(1'($urandom_range(1)));
        drain();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
